// ===== design/clma_pkg.sv =====
// Shared types and constants for the cluster label match accuracy block.
package clma_pkg;

    localparam int DEF_MAX_CLUSTERS = 16;
    localparam int DEF_COUNT_BITS   = 20;
    localparam int LABEL_W          = 4;
    localparam int CFG_W            = 5;
    localparam int OUT_W            = 20;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;
    localparam logic [OUT_W-1:0] OUT_MAX   = {OUT_W{1'b1}};

    // Values of the action flag carried on s_tuser.
    localparam logic ACT_ACCUMULATE = 1'b0;
    localparam logic ACT_FINISH     = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_RUN_END,
        ST_REPORT
    } clma_state_t;

    // Sequencer commands to the matching unit.
    typedef struct packed {
        logic cmp_en;
        logic commit;
        logic run_end;
        logic clear;
    } clma_ctrl_t;

endpackage

// ===== design/clma_match_unit.sv =====
// Compare and accumulate unit shared by every step of the greedy matching.
module clma_match_unit
    import clma_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS,
    localparam int IDX_W       = $clog2(MAX_CLUSTERS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  clma_ctrl_t            ctrl,
    input  logic [IDX_W-1:0]      cmp_col,
    input  logic [COUNT_BITS-1:0] rd_data,
    output logic [COUNT_BITS-1:0] best_total
);

    logic [COUNT_BITS-1:0]   best_reg;
    logic [IDX_W-1:0]        pick_reg;
    logic [MAX_CLUSTERS-1:0] claimed_reg;
    logic [COUNT_BITS-1:0]   run_total_reg;
    logic [COUNT_BITS-1:0]   best_total_reg;
    logic [COUNT_BITS:0]     sum;
    logic [COUNT_BITS-1:0]   run_total_next;
    logic                    take;

    assign take = ctrl.cmp_en && !claimed_reg[cmp_col] && (rd_data > best_reg);
    assign sum  = {1'b0, run_total_reg} + {1'b0, best_reg};
    assign run_total_next = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            best_reg       <= '0;
            pick_reg       <= '0;
            claimed_reg    <= '0;
            run_total_reg  <= '0;
            best_total_reg <= '0;
        end else begin
            if (take) begin
                best_reg <= rd_data;
                pick_reg <= cmp_col;
            end
            if (ctrl.commit) begin
                // With no positive count left the pick stays at label 0.
                claimed_reg[pick_reg] <= 1'b1;
                run_total_reg         <= run_total_next;
                best_reg              <= '0;
                pick_reg              <= '0;
            end
            if (ctrl.run_end) begin
                if (run_total_reg > best_total_reg) begin
                    best_total_reg <= run_total_reg;
                end
                run_total_reg <= '0;
                claimed_reg   <= '0;
            end
        end
    end

    assign best_total = best_total_reg;

endmodule

// ===== design/cluster_label_match_accuracy_core.sv =====
// Top level: confusion matrix accumulation and greedy label matching sequencer.
//
// Input transfers carry one pixel label pair (s_tuser = 0) or a finish
// command (s_tuser = 1). For a pair the matrix cell is read on the
// accepting edge and written back incremented on the next. The matrix
// is a single-port-write memory, so the next pair waits for the write back.
// A finish runs C greedy passes over the C x C matrix (C is the clamped
// cluster count), reading one cell per cycle through one comparator and one
// saturating adder, then loads the result once the output register is free.
// One result transfer follows each finish; accumulate transfers give none.
// After the result is loaded the matrix is swept clear, one cell per cycle,
// all 2^(2*ceil(log2(MAX_CLUSTERS))) cells (256 by default), with s_tready low.
// The same sweep runs after reset before the first item is taken.
// The result waits in an output register while m_tready is low; the block
// keeps working, and only a later finish stalls until that register is free.
// cfg_we may be asserted at any idle time; the cluster count is kept across
// finish and reset to 2.
module cluster_label_match_accuracy_core
    import clma_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,     // cluster_count
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,       // [3:0] truth_label, [7:4] result_label
    input  logic [0:0]         s_tuser,       // [0] action
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata        // [19:0] matched_count, [39:20] pixel_count
);

    localparam int IDX_W     = $clog2(MAX_CLUSTERS);
    localparam int CW        = $clog2(MAX_CLUSTERS + 1);
    localparam int AW        = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int XW        = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    clma_state_t state_reg, state_next;

    logic [CFG_W-1:0]      cluster_count_reg;
    logic [CW-1:0]         used_clusters;
    logic [CW-1:0]         c_reg;
    logic [IDX_W-1:0]      c_last;
    logic [IDX_W-1:0]      col_reg, row_reg, k_reg, s_reg;
    logic                  cmp_en_reg;
    logic [IDX_W-1:0]      cmp_col_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic [AW-1:0]         acc_addr_reg;
    logic                  acc_hit_reg;
    logic [COUNT_BITS-1:0] pixels_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_matched_reg, m_pixel_reg;

    logic [COUNT_BITS-1:0] mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_data;

    logic [LABEL_W-1:0]    truth_label, result_label;
    logic                  action;
    logic                  label_hit;
    logic                  out_free;
    logic                  load_out;
    clma_ctrl_t            ctrl;
    logic [COUNT_BITS-1:0] best_total;
    logic [XW-1:0]         best_ext, pix_ext;
    logic [OUT_W-1:0]      matched_out, pixel_out;

    assign truth_label  = s_tdata[3:0];
    assign result_label = s_tdata[7:4];
    assign action       = s_tuser[0];
    assign label_hit    = (int'(truth_label) < MAX_CLUSTERS) &&
                          (int'(result_label) < MAX_CLUSTERS);
    assign out_free     = !m_tvalid_reg || m_tready;

    always_comb begin
        if (cluster_count_reg == '0) begin
            used_clusters = CW'(1);
        end else if (int'(cluster_count_reg) > MAX_CLUSTERS) begin
            used_clusters = CW'(MAX_CLUSTERS);
        end else begin
            used_clusters = CW'(cluster_count_reg);
        end
    end

    assign c_last = IDX_W'(c_reg - 1'b1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == {AW{1'b1}}) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (action == ACT_FINISH) ? ST_SCAN : ST_ACC_WR;
                end
            end
            ST_ACC_WR:  state_next = ST_IDLE;
            ST_SCAN: begin
                if (col_reg == c_last) state_next = ST_DRAIN;
            end
            ST_DRAIN:   state_next = ST_COMMIT;
            ST_COMMIT:  state_next = (k_reg == c_last) ? ST_RUN_END : ST_SCAN;
            ST_RUN_END: state_next = (s_reg == c_last) ? ST_REPORT : ST_SCAN;
            ST_REPORT: begin
                if (out_free) state_next = ST_CLEAR;
            end
            default:    state_next = ST_CLEAR;
        endcase
    end

    // State outputs: handshake, memory port and unit commands.
    always_comb begin
        s_tready     = 1'b0;
        rd_addr      = {row_reg, col_reg};
        wr_en        = 1'b0;
        wr_addr      = clr_addr_reg;
        wr_data      = '0;
        load_out     = 1'b0;
        ctrl.cmp_en  = cmp_en_reg;
        ctrl.commit  = 1'b0;
        ctrl.run_end = 1'b0;
        ctrl.clear   = 1'b0;
        case (state_reg)
            ST_CLEAR:   wr_en = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                rd_addr  = {IDX_W'(truth_label), IDX_W'(result_label)};
            end
            ST_ACC_WR: begin
                wr_en   = acc_hit_reg;
                wr_addr = acc_addr_reg;
                wr_data = (rd_data_reg == CNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;
            end
            ST_COMMIT:  ctrl.commit = 1'b1;
            ST_RUN_END: ctrl.run_end = 1'b1;
            ST_REPORT: begin
                load_out   = out_free;
                ctrl.clear = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    clma_match_unit #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .cmp_col    (cmp_col_reg),
        .rd_data    (rd_data_reg),
        .best_total (best_total)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            cluster_count_reg <= CFG_RESET;
            c_reg             <= CW'(1);
            col_reg           <= '0;
            row_reg           <= '0;
            k_reg             <= '0;
            s_reg             <= '0;
            cmp_en_reg        <= 1'b0;
            clr_addr_reg      <= '0;
            acc_hit_reg       <= 1'b0;
            pixels_reg        <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cmp_en_reg <= (state_reg == ST_SCAN);
            if (cfg_we) begin
                cluster_count_reg <= cfg_wdata;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: clr_addr_reg <= clr_addr_reg + 1'b1;
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (action == ACT_FINISH) begin
                            c_reg   <= used_clusters;
                            col_reg <= '0;
                            row_reg <= '0;
                            k_reg   <= '0;
                            s_reg   <= '0;
                        end else begin
                            acc_hit_reg <= label_hit;
                            if (pixels_reg != CNT_MAX) pixels_reg <= pixels_reg + 1'b1;
                        end
                    end
                end
                ST_SCAN: col_reg <= col_reg + 1'b1;
                ST_COMMIT: begin
                    col_reg <= '0;
                    k_reg   <= k_reg + 1'b1;
                    row_reg <= (row_reg == c_last) ? '0 : row_reg + 1'b1;
                end
                ST_RUN_END: begin
                    // The next run starts one truth row further on.
                    s_reg   <= s_reg + 1'b1;
                    row_reg <= s_reg + 1'b1;
                    k_reg   <= '0;
                end
                ST_REPORT: begin
                    if (out_free) begin
                        pixels_reg   <= '0;
                        clr_addr_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign best_ext    = XW'(best_total);
    assign pix_ext     = XW'(pixels_reg);
    assign matched_out = (best_ext > XW'(OUT_MAX)) ? OUT_MAX : OUT_W'(best_ext);
    assign pixel_out   = (pix_ext > XW'(OUT_MAX)) ? OUT_MAX : OUT_W'(pix_ext);

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        cmp_col_reg <= col_reg;
        if (state_reg == ST_IDLE) begin
            acc_addr_reg <= {IDX_W'(truth_label), IDX_W'(result_label)};
        end
        if (load_out) begin
            m_matched_reg <= matched_out;
            m_pixel_reg   <= pixel_out;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_pixel_reg, m_matched_reg};

endmodule

// ===== dv/tb.sv =====
// Testbench for cluster_label_match_accuracy_core: directed table plus random frames, self-checked.
module tb
    import clma_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 300;    // covers the clearing sweep of 256 cells
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS   = 500;
    localparam int NUM_DIRECTED   = 26;
    localparam int NCLU           = DEF_MAX_CLUSTERS;

    localparam logic [DEF_COUNT_BITS-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic [OUT_W-1:0] pixels;
        logic [OUT_W-1:0] matched;
    } accuracy_report_t;

    typedef struct packed {
        logic             set_cfg;
        logic [CFG_W-1:0] cfg_val;
        logic             act;
        logic [3:0]       truth;
        logic [3:0]       res;
        logic             typed;
        logic [OUT_W-1:0] exp_matched;
        logic [OUT_W-1:0] exp_pixels;
    } stim_row_t;

    // cfg flag, cfg value, action, truth, result label, typed flag, matched, pixels
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{0,  0, ACT_FINISH,     0,  0, 1, 0, 0},  // empty matrix right after reset
        '{0,  0, ACT_ACCUMULATE, 0,  0, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 15, 15, 0, 0, 0}, // labels beyond the cluster count
        '{0,  0, ACT_ACCUMULATE, 1,  1, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 1,  0, 0, 0, 0},
        '{0,  0, ACT_FINISH,     15, 15, 0, 0, 0},
        '{1,  0, ACT_ACCUMULATE, 0,  5, 0, 0, 0},  // a count of zero acts as one
        '{0,  0, ACT_ACCUMULATE, 0,  0, 0, 0, 0},
        '{0,  0, ACT_FINISH,     10, 5, 1, 1, 2},
        '{1, 31, ACT_ACCUMULATE, 15, 0, 0, 0, 0},  // above the maximum acts as sixteen
        '{0,  0, ACT_ACCUMULATE, 15, 0, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 0, 15, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 7,  8, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 8,  7, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 3,  3, 0, 0, 0},
        '{0,  0, ACT_FINISH,     0,  0, 0, 0, 0},
        '{0,  0, ACT_FINISH,     5, 10, 1, 0, 0},  // back-to-back finish sees a cleared matrix
        '{1,  1, ACT_ACCUMULATE, 0,  0, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 0,  0, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 0,  1, 0, 0, 0},
        '{0,  0, ACT_FINISH,     0,  0, 1, 2, 3},
        '{1, 16, ACT_ACCUMULATE, 5,  9, 0, 0, 0},
        '{0,  0, ACT_ACCUMULATE, 9,  5, 0, 0, 0},
        '{0,  0, ACT_FINISH,     15, 0, 0, 0, 0},
        '{1,  2, ACT_ACCUMULATE, 0,  1, 0, 0, 0},  // second row finds no positive count
        '{0,  0, ACT_FINISH,     3,  3, 0, 0, 0}
    };

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = CFG_RESET;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // [3:0] truth_label, [7:4] result_label
    logic [0:0]        s_tuser   = '0;   // [0] action
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [39:0]       m_tdata;          // [19:0] matched_count, [39:20] pixel_count

    // Mirror of the block's state.
    logic [DEF_COUNT_BITS-1:0] conf_matrix [NCLU][NCLU];
    logic [DEF_COUNT_BITS-1:0] pixel_tally;
    logic [CFG_W-1:0]          cluster_sel;

    accuracy_report_t pending_reports [$];

    int  failures     = 0;
    int  items_sent   = 0;
    int  reports_sent = 0;
    int  quiet_cycles = 0;
    bit  sender_idle  = 1'b1;
    bit  recv_idle    = 1'b1;
    bit  hold_pending = 1'b0;

    cluster_label_match_accuracy_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_tally();
        for (int i = 0; i < NCLU; i++) begin
            for (int j = 0; j < NCLU; j++) begin
                conf_matrix[i][j] = '0;
            end
        end
        pixel_tally = '0;
    endfunction

    function automatic int clamp_clusters(input logic [CFG_W-1:0] v);
        if (v < 1) begin
            return 1;
        end
        if (v > NCLU) begin
            return NCLU;
        end
        return int'(v);
    endfunction

    function automatic void count_pair(input logic [3:0] truth, input logic [3:0] res);
        if (pixel_tally != COUNT_SAT) begin
            pixel_tally = pixel_tally + 1'b1;
        end
        if (conf_matrix[truth][res] != COUNT_SAT) begin
            conf_matrix[truth][res] = conf_matrix[truth][res] + 1'b1;
        end
    endfunction

    // Greedy matching from every start row; keeps the best total, then clears.
    function automatic accuracy_report_t finish_report();
        accuracy_report_t rep;
        int               c;
        int               row;
        int               pick;
        longint unsigned  top;
        longint unsigned  run_total;
        longint unsigned  best_overall;
        bit [NCLU-1:0]    taken;
        c = clamp_clusters(cluster_sel);
        best_overall = 0;
        for (int s = 0; s < c; s++) begin
            taken = '0;
            run_total = 0;
            for (int k = 0; k < c; k++) begin
                row = (s + k) % c;
                top = 0;
                pick = 0;
                for (int e = 0; e < c; e++) begin
                    if (!taken[e] && 64'(conf_matrix[row][e]) > top) begin
                        top = 64'(conf_matrix[row][e]);
                        pick = e;
                    end
                end
                // With nothing positive left, label 0 is taken and nothing is added.
                taken[pick] = 1'b1;
                run_total = run_total + top;
                if (run_total > 64'(COUNT_SAT)) begin
                    run_total = 64'(COUNT_SAT);
                end
            end
            if (run_total > best_overall) begin
                best_overall = run_total;
            end
        end
        rep.matched = (best_overall > 64'(OUT_MAX)) ? OUT_MAX : best_overall[OUT_W-1:0];
        rep.pixels  = (pixel_tally > OUT_MAX) ? OUT_MAX : pixel_tally[OUT_W-1:0];
        clear_tally();
        return rep;
    endfunction

    task automatic send_item(input logic act, input logic [3:0] truth, input logic [3:0] res,
                             input bit typed, input accuracy_report_t typed_rep);
        int               gap;
        accuracy_report_t predicted;
        gap = sender_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {res, truth};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (act == ACT_FINISH) begin
            predicted = finish_report();
            if (typed) begin
                predicted = typed_rep;
            end
            pending_reports = {pending_reports, predicted};
            reports_sent++;
        end else begin
            count_pair(truth, res);
        end
    endtask

    // The register is only written once all reports are back and the sweep is done.
    task automatic write_cluster_count(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        cluster_sel = value;
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial begin
        int               w;
        accuracy_report_t want;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                w = HOLD_CYCLES;
            end else begin
                w = recv_idle ? $urandom_range(0, 13) : 0;
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_reports.size() == 0) begin
                $error("unexpected result transfer: matched_count %0d, pixel_count %0d",
                       m_tdata[19:0], m_tdata[39:20]);
                failures++;
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[19:0] !== want.matched) begin
                    $error("matched_count: expected %0d, got %0d", want.matched, m_tdata[19:0]);
                    failures++;
                end
                if (m_tdata[39:20] !== want.pixels) begin
                    $error("pixel_count: expected %0d, got %0d", want.pixels, m_tdata[39:20]);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("** cluster_label_match_accuracy_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int               n_pairs;
        int               frames;
        int               c_eff;
        int               shift;
        int               phase;
        int               t;
        int               r;
        bit               noisy;
        logic [CFG_W-1:0] cfg_pick;
        accuracy_report_t no_rep;
        no_rep = '0;
        clear_tally();
        cluster_sel = CFG_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_rows[i].set_cfg) begin
                write_cluster_count(directed_rows[i].cfg_val);
            end
            sender_idle = ($urandom_range(0, 1) != 0);
            send_item(directed_rows[i].act, directed_rows[i].truth, directed_rows[i].res,
                      directed_rows[i].typed,
                      '{pixels: directed_rows[i].exp_pixels,
                        matched: directed_rows[i].exp_matched});
        end

        // Random frames: label pairs then a finish. The first phase runs under a
        // long result stall so that finishes back up and the input stalls.
        phase = 0;
        while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       cfg_pick = CFG_W'($urandom_range(16, 31));
                1:       cfg_pick = '0;
                default: cfg_pick = CFG_W'($urandom_range(1, 6));
            endcase
            if (phase == 0) begin
                cfg_pick = 5'd3;
            end
            write_cluster_count(cfg_pick);
            c_eff = clamp_clusters(cfg_pick);
            sender_idle = ($urandom_range(0, 3) != 0);
            recv_idle   = ($urandom_range(0, 3) != 0);
            frames = (phase == 0) ? 6 : $urandom_range(2, 5);
            if (phase == 0) begin
                hold_pending = 1'b1;
            end
            for (int f = 0; f < frames; f++) begin
                noisy = ($urandom_range(0, 5) == 0);
                shift = $urandom_range(0, c_eff - 1);
                if (phase == 0) begin
                    n_pairs = $urandom_range(1, 4);
                end else if ($urandom_range(0, 11) == 0) begin
                    n_pairs = $urandom_range(40, 80);
                end else begin
                    n_pairs = $urandom_range(0, 16);
                end
                for (int p = 0; p < n_pairs; p++) begin
                    if (noisy) begin
                        t = $urandom_range(0, 15);
                        r = $urandom_range(0, 15);
                    end else begin
                        t = $urandom_range(0, c_eff - 1);
                        r = ($urandom_range(0, 3) != 0) ? (t + shift) % c_eff
                                                        : $urandom_range(0, c_eff - 1);
                    end
                    send_item(ACT_ACCUMULATE, t[3:0], r[3:0], 1'b0, no_rep);
                end
                t = $urandom_range(0, 15);
                r = $urandom_range(0, 15);
                send_item(ACT_FINISH, t[3:0], r[3:0], 1'b0, no_rep);
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("** cluster_label_match_accuracy_core: PASSED **");
        end else begin
            $display("** cluster_label_match_accuracy_core: FAILED **");
        end
        $finish;
    end

endmodule
